>>> hdl/ngr_pkg.sv
// ----------------------------------------------------------------------------
// ngr_pkg
// Shared types, character codes and helper functions for the NMEA GGA/RMC
// sentence parser.
// ----------------------------------------------------------------------------
package ngr_pkg;

    localparam int FIELD_CHARS_MAX = 16;
    localparam int FIELDS_MAX      = 31;
    localparam int FL_W            = $clog2(FIELD_CHARS_MAX + 2);
    localparam int FN_W            = $clog2(FIELDS_MAX + 1);
    localparam int BUF_CHARS       = 6;
    localparam int SEC_START       = 4;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RMC  = 2'd1,
        KIND_GGA  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_REJECT  = 2'd0,
        ST_RMC_NOP = 2'd1,
        ST_RMC_POS = 2'd2,
        ST_GGA     = 2'd3
    } status_t;

    // running state of one decimal number parse
    typedef struct packed {
        logic        neg;
        logic        bad;
        logic        pnt;
        logic        dig;
        logic        nz;
        logic [23:0] whole;
        logic [7:0]  hi;
        logic [3:0]  t1;
        logic [3:0]  t0;
        logic [3:0]  fcnt;
        logic [6:0]  frac2;
        logic [9:0]  frac3;
        logic [16:0] frac5;
        logic        fnz;
    } num_t;

    typedef struct packed {
        logic            feed;
        logic            close;
        logic            clear;
        logic [FL_W-1:0] pos;
        logic [FN_W-1:0] fnum;
    } fd_ctrl_t;

    typedef struct packed {
        kind_t       kind;
        logic        time_ok;
        logic [26:0] time_ms;
        logic        active;
        logic        date_ok;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
        logic        lat_ok;
        logic        lat_neg;
        logic [7:0]  lat_deg;
        logic [22:0] lat_mfix;
        logic        lon_ok;
        logic        lon_neg;
        logic [7:0]  lon_deg;
        logic [22:0] lon_mfix;
        logic        fix_ok;
        logic [7:0]  fix;
        logic [7:0]  sats;
        logic [15:0] hdop;
        logic [2:0]  present;
        logic [26:0] alt_mag;
        logic        alt_neg;
    } fld_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] val;
    } su2_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c inside {[CH_0:CH_9]});
    endfunction

    function automatic num_t num_step(input num_t s, input logic [7:0] c, input logic first);
        num_t        n;
        logic [3:0]  d;
        logic [27:0] wp;
        logic [11:0] hp;
        n  = first ? '0 : s;
        d  = c[3:0];
        wp = {4'd0, n.whole} * 28'd10 + {24'd0, d};
        hp = {4'd0, n.hi} * 12'd10 + {8'd0, n.t1};
        if (is_digit(c)) begin
            n.dig = 1'b1;
            if (d != 4'd0) n.nz = 1'b1;
            if (!n.pnt) begin
                n.whole = (wp > 28'hFF_FFFF) ? 24'hFF_FFFF : wp[23:0];
                n.hi    = (hp > 12'd255) ? 8'd255 : hp[7:0];
                n.t1    = n.t0;
                n.t0    = d;
            end else if (n.fcnt < 4'd8) begin
                if (d != 4'd0) n.fnz = 1'b1;
                case (n.fcnt)
                    4'd0: begin
                        n.frac5 = n.frac5 + 17'(d) * 17'd10000;
                        n.frac3 = n.frac3 + 10'(d) * 10'd100;
                        n.frac2 = n.frac2 + 7'(d) * 7'd10;
                    end
                    4'd1: begin
                        n.frac5 = n.frac5 + 17'(d) * 17'd1000;
                        n.frac3 = n.frac3 + 10'(d) * 10'd10;
                        n.frac2 = n.frac2 + 7'(d);
                    end
                    4'd2: begin
                        n.frac5 = n.frac5 + 17'(d) * 17'd100;
                        n.frac3 = n.frac3 + 10'(d);
                    end
                    4'd3: n.frac5 = n.frac5 + 17'(d) * 17'd10;
                    4'd4: n.frac5 = n.frac5 + 17'(d);
                    default: ;
                endcase
                n.fcnt = n.fcnt + 4'd1;
            end
        end else if (c == CH_DOT && !n.pnt) begin
            n.pnt = 1'b1;
        end else if (first && (c == CH_PLUS || c == CH_MINUS)) begin
            n.neg = (c == CH_MINUS);
        end else begin
            n.bad = 1'b1;
        end
        num_step = n;
    endfunction

    // two-character unsigned integer, optional sign, minus zero is zero
    function automatic su2_t su2(input logic [7:0] c0, input logic [7:0] c1);
        su2_t r;
        r = '0;
        if (is_digit(c0) && is_digit(c1)) begin
            r.ok  = 1'b1;
            r.val = 7'(c0[3:0]) * 7'd10 + 7'(c1[3:0]);
        end else if ((c0 == CH_PLUS || c0 == CH_MINUS) && is_digit(c1)) begin
            r.val = 7'(c1[3:0]);
            r.ok  = !(c0 == CH_MINUS && c1[3:0] != 4'd0);
        end
        su2 = r;
    endfunction

endpackage

>>> hdl/ngr_coord_cvt.sv
// ----------------------------------------------------------------------------
// ngr_coord_cvt
// Converts degrees plus minutes (1e-5 minute units) to 1e-7 degrees:
// deg * 1e7 + floor(mfix * 5 / 3), registered.
// ----------------------------------------------------------------------------
module ngr_coord_cvt
    import ngr_pkg::*;
(
    input  logic        aclk,
    input  logic [7:0]  deg,
    input  logic [22:0] mfix,
    output logic [30:0] mag
);

    localparam logic [24:0] RECIP3 = 25'd22369622;

    logic [25:0] x5;
    logic [50:0] prod;
    logic [32:0] sum;
    logic [30:0] mag_reg;
    logic [30:0] mag_next;

    always_comb begin
        x5       = {3'd0, mfix} + {1'b0, mfix, 2'b00};
        prod     = 51'(x5) * 51'(RECIP3);
        sum      = 33'(deg) * 33'd10000000 + 33'(prod[50:26]);
        mag_next = sum[30:0];
    end

    always_ff @(posedge aclk) begin
        mag_reg <= mag_next;
    end

    assign mag = mag_reg;

endmodule

>>> hdl/ngr_field_dec.sv
// ----------------------------------------------------------------------------
// ngr_field_dec
// Per-field number parsing and decode of the sentence fields into the
// held result set.
// ----------------------------------------------------------------------------
module ngr_field_dec
    import ngr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fd_ctrl_t    ctrl,
    input  logic [7:0]  byte_in,
    output fld_t        held,
    output logic [30:0] lat_mag,
    output logic [30:0] lon_mag
);

    logic [7:0]  buf_reg [BUF_CHARS];
    num_t        num_a_reg, num_a_next;
    num_t        num_b_reg, num_b_next;
    fld_t        hr_reg, hr_next;

    logic            len_ok, a_ok, a_iok, b_ok, dir1;
    logic [FL_W-1:0] len;
    logic [6:0]      mins;
    logic            cok, lat_cok, lon_cok;
    logic [22:0]     mfix;
    su2_t            su_h, su_m, su_y;
    logic            t_ok, d_ok;
    logic [26:0]     t_ms;
    logic [30:0]     c_hd;
    logic [7:0]      w_sat;

    always_comb begin
        len    = ctrl.pos;
        len_ok = (len != '0) && (len <= FL_W'(FIELD_CHARS_MAX));
        a_ok   = len_ok && !num_a_reg.bad && num_a_reg.dig;
        a_iok  = a_ok && !num_a_reg.pnt;
        b_ok   = !num_b_reg.bad && num_b_reg.dig;
        dir1   = (len == FL_W'(1));
        w_sat  = (num_a_reg.whole > 24'd255) ? 8'd255 : num_a_reg.whole[7:0];

        mins    = 7'(num_a_reg.t1) * 7'd10 + 7'(num_a_reg.t0);
        cok     = a_ok && !(num_a_reg.neg && num_a_reg.nz) && (mins < 7'd60);
        lat_cok = cok && (num_a_reg.hi <= 8'd90) &&
                  !(num_a_reg.hi == 8'd90 && (mins != 7'd0 || num_a_reg.fnz));
        lon_cok = cok && (num_a_reg.hi <= 8'd180) &&
                  !(num_a_reg.hi == 8'd180 && (mins != 7'd0 || num_a_reg.fnz));
        mfix    = 23'(mins) * 23'd100000 + 23'(num_a_reg.frac5);

        su_h = su2(buf_reg[0], buf_reg[1]);
        su_m = su2(buf_reg[2], buf_reg[3]);
        su_y = su2(buf_reg[4], buf_reg[5]);

        t_ok = (len >= FL_W'(6)) && (len <= FL_W'(FIELD_CHARS_MAX)) &&
               su_h.ok && (su_h.val <= 7'd23) && su_m.ok && (su_m.val <= 7'd59) &&
               b_ok && !(num_b_reg.neg && num_b_reg.nz) && (num_b_reg.whole < 24'd60);
        t_ms = 27'(su_h.val) * 27'd3600000 + 27'(su_m.val) * 27'd60000 +
               27'(num_b_reg.whole[5:0]) * 27'd1000 + 27'(num_b_reg.frac3);

        d_ok = (len == FL_W'(6)) && su_h.ok && (su_h.val <= 7'd31) && (su_h.val >= 7'd1) &&
               su_m.ok && (su_m.val <= 7'd12) && (su_m.val >= 7'd1) &&
               su_y.ok && (su_y.val <= 7'd99);

        c_hd = 31'(num_a_reg.whole) * 31'd100 + 31'(num_a_reg.frac2);

        hr_next = hr_reg;
        if (ctrl.clear) begin
            hr_next = '0;
        end else if (ctrl.close) begin
            if (ctrl.fnum == '0) begin
                hr_next.kind = KIND_NONE;
                if (len == FL_W'(6) && buf_reg[3] == CH_R && buf_reg[4] == CH_M &&
                    buf_reg[5] == CH_C) begin
                    hr_next.kind = KIND_RMC;
                end else if (len == FL_W'(6) && buf_reg[3] == CH_G && buf_reg[4] == CH_G &&
                             buf_reg[5] == CH_A) begin
                    hr_next.kind = KIND_GGA;
                end
            end else if (ctrl.fnum == FN_W'(1) && hr_reg.kind != KIND_NONE) begin
                hr_next.time_ok = t_ok;
                if (t_ok) hr_next.time_ms = t_ms;
            end else if (hr_reg.kind == KIND_RMC) begin
                case (ctrl.fnum)
                    FN_W'(2): hr_next.active = dir1 && buf_reg[0] == CH_A;
                    FN_W'(3): begin
                        hr_next.lat_ok   = lat_cok;
                        hr_next.lat_deg  = num_a_reg.hi;
                        hr_next.lat_mfix = mfix;
                    end
                    FN_W'(4): begin
                        hr_next.lat_neg = dir1 && buf_reg[0] == CH_S;
                        hr_next.lat_ok  = hr_reg.lat_ok && dir1 &&
                                          (buf_reg[0] == CH_N || buf_reg[0] == CH_S);
                    end
                    FN_W'(5): begin
                        hr_next.lon_ok   = lon_cok;
                        hr_next.lon_deg  = num_a_reg.hi;
                        hr_next.lon_mfix = mfix;
                    end
                    FN_W'(6): begin
                        hr_next.lon_neg = dir1 && buf_reg[0] == CH_W;
                        hr_next.lon_ok  = hr_reg.lon_ok && dir1 &&
                                          (buf_reg[0] == CH_E || buf_reg[0] == CH_W);
                    end
                    FN_W'(9): begin
                        hr_next.date_ok = d_ok;
                        hr_next.day     = su_h.val[4:0];
                        hr_next.month   = su_m.val[3:0];
                        hr_next.year    = (su_y.val >= 7'd80) ? 12'd1900 + 12'(su_y.val)
                                                              : 12'd2000 + 12'(su_y.val);
                    end
                    default: ;
                endcase
            end else if (hr_reg.kind == KIND_GGA) begin
                case (ctrl.fnum)
                    FN_W'(2): begin
                        hr_next.lat_ok   = lat_cok;
                        hr_next.lat_deg  = num_a_reg.hi;
                        hr_next.lat_mfix = mfix;
                    end
                    FN_W'(3): begin
                        hr_next.lat_neg = dir1 && buf_reg[0] == CH_S;
                        hr_next.lat_ok  = hr_reg.lat_ok && dir1 &&
                                          (buf_reg[0] == CH_N || buf_reg[0] == CH_S);
                    end
                    FN_W'(4): begin
                        hr_next.lon_ok   = lon_cok;
                        hr_next.lon_deg  = num_a_reg.hi;
                        hr_next.lon_mfix = mfix;
                    end
                    FN_W'(5): begin
                        hr_next.lon_neg = dir1 && buf_reg[0] == CH_W;
                        hr_next.lon_ok  = hr_reg.lon_ok && dir1 &&
                                          (buf_reg[0] == CH_E || buf_reg[0] == CH_W);
                    end
                    FN_W'(6): begin
                        hr_next.fix_ok = a_iok && !num_a_reg.neg && (num_a_reg.whole != 24'd0);
                        hr_next.fix    = w_sat;
                    end
                    FN_W'(7): begin
                        if (a_iok) begin
                            hr_next.present[0] = 1'b1;
                            hr_next.sats       = num_a_reg.neg ? 8'd0 : w_sat;
                        end
                    end
                    FN_W'(8): begin
                        if (a_ok) begin
                            hr_next.present[1] = 1'b1;
                            hr_next.hdop = num_a_reg.neg ? 16'd0 :
                                           (c_hd > 31'd65535) ? 16'hFFFF : c_hd[15:0];
                        end
                    end
                    FN_W'(9): begin
                        if (a_ok) begin
                            hr_next.present[2] = 1'b1;
                            hr_next.alt_mag = (c_hd > 31'd100000000) ? 27'd100000000
                                                                     : c_hd[26:0];
                            hr_next.alt_neg = num_a_reg.neg;
                        end
                    end
                    default: ;
                endcase
            end
        end

        num_a_next = num_a_reg;
        num_b_next = num_b_reg;
        if (ctrl.feed) begin
            num_a_next = num_step(num_a_reg, byte_in, ctrl.pos == '0);
            if (ctrl.pos >= FL_W'(SEC_START)) begin
                num_b_next = num_step(num_b_reg, byte_in, ctrl.pos == FL_W'(SEC_START));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hr_reg <= '0;
        end else begin
            hr_reg <= hr_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_a_reg <= num_a_next;
        num_b_reg <= num_b_next;
        if (ctrl.feed && ctrl.pos < FL_W'(BUF_CHARS)) begin
            buf_reg[ctrl.pos[$clog2(BUF_CHARS)-1:0]] <= byte_in;
        end
    end

    ngr_coord_cvt u_lat_cvt (
        .aclk (aclk),
        .deg  (hr_reg.lat_deg),
        .mfix (hr_reg.lat_mfix),
        .mag  (lat_mag)
    );

    ngr_coord_cvt u_lon_cvt (
        .aclk (aclk),
        .deg  (hr_reg.lon_deg),
        .mfix (hr_reg.lon_mfix),
        .mag  (lon_mag)
    );

    assign held = hr_reg;

endmodule

>>> hdl/nmea_gga_rmc_sentence_parser_top.sv
// ----------------------------------------------------------------------------
// nmea_gga_rmc_sentence_parser_top
// NMEA 0183 GGA/RMC sentence checker and parser, one character per transfer.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while s_tready is high; no stall between sentences.
// Output: the result is registered and appears on m_ in the cycle after the
// transfer of the character marked by s_tlast; a full output register blocks
// input only while m_tready is low.
// Reset: aresetn (synchronous, active low) returns framing to wait for '$'.
module nmea_gga_rmc_sentence_parser_top
    import ngr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // byte_in[7:0]
    input  logic         s_tlast,   // is_last
    output logic         m_tvalid,
    input  logic         m_tready,
    // time_of_day_ms, day, month, year, latitude, longitude, fix_qual,
    // satellites, hdop_centi, altitude_cm, present_mask, zero pad
    output logic [175:0] m_tdata,
    output logic [1:0]   m_tuser    // status
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_HEX1,
        PH_HEX2,
        PH_TAIL
    } phase_t;

    phase_t          phase_reg, phase_next, phase_p;
    logic [7:0]      xor_reg, xor_next, xor_p;
    logic [7:0]      recv_reg, recv_next, recv_p;
    logic [FN_W-1:0] fn_reg, fn_next, fn_p;
    logic [FL_W-1:0] fl_reg, fl_next, fl_p;
    logic            err_reg, err_next, err_p;
    logic            m_valid_reg, m_valid_next;
    logic [175:0]    m_data_reg, m_data_next;
    logic [1:0]      m_user_reg, m_user_next;

    logic        xfer;
    logic        hex_ok;
    logic [3:0]  hex_val;
    fd_ctrl_t    ctrl;
    fld_t        held;
    logic [30:0] lat_mag, lon_mag;
    logic        base_ok;
    status_t     status;
    logic [30:0] lat_o;
    logic [31:0] lon_o;
    logic [27:0] alt_o;

    assign s_tready = !m_valid_reg || m_tready;
    assign xfer     = s_tvalid && s_tready;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (is_digit(s_tdata)) begin
            hex_val = s_tdata[3:0];
        end else if (s_tdata inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            hex_val = s_tdata[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        phase_p = phase_reg;
        xor_p   = xor_reg;
        recv_p  = recv_reg;
        fn_p    = fn_reg;
        fl_p    = fl_reg;
        err_p   = err_reg;
        ctrl    = '0;
        ctrl.pos  = fl_reg;
        ctrl.fnum = fn_reg;
        if (xfer) begin
            case (phase_reg)
                PH_IDLE: begin
                    if (s_tdata == CH_DOLLAR) begin
                        phase_p = PH_BODY;
                        fl_p    = FL_W'(1);
                    end else begin
                        err_p   = 1'b1;
                        phase_p = PH_TAIL;
                    end
                end
                PH_BODY: begin
                    if (s_tdata == CH_STAR) begin
                        ctrl.close = 1'b1;
                        phase_p    = PH_HEX1;
                    end else begin
                        xor_p = xor_reg ^ s_tdata;
                        if (s_tdata == CH_COMMA) begin
                            ctrl.close = 1'b1;
                            if (fn_reg < FN_W'(FIELDS_MAX)) fn_p = fn_reg + FN_W'(1);
                            fl_p = '0;
                        end else begin
                            ctrl.feed = 1'b1;
                            if (fl_reg <= FL_W'(FIELD_CHARS_MAX)) fl_p = fl_reg + FL_W'(1);
                        end
                    end
                end
                PH_HEX1: begin
                    if (!hex_ok) err_p = 1'b1;
                    else recv_p = {hex_val, 4'd0};
                    phase_p = PH_HEX2;
                end
                PH_HEX2: begin
                    if (!hex_ok) err_p = 1'b1;
                    else recv_p = recv_reg | {4'd0, hex_val};
                    phase_p = PH_TAIL;
                end
                PH_TAIL: ;
                default: ;
            endcase
        end

        ctrl.clear = xfer && s_tlast;

        if (xfer && s_tlast) begin
            phase_next = PH_IDLE;
            xor_next   = '0;
            recv_next  = '0;
            fn_next    = '0;
            fl_next    = '0;
            err_next   = 1'b0;
        end else begin
            phase_next = phase_p;
            xor_next   = xor_p;
            recv_next  = recv_p;
            fn_next    = fn_p;
            fl_next    = fl_p;
            err_next   = err_p;
        end
    end

    ngr_field_dec u_field_dec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .byte_in (s_tdata),
        .held    (held),
        .lat_mag (lat_mag),
        .lon_mag (lon_mag)
    );

    always_comb begin
        base_ok = !err_p && phase_p == PH_TAIL && xor_p == recv_p && fn_p >= FN_W'(9);
        status  = ST_REJECT;
        if (base_ok) begin
            if (held.kind == KIND_RMC && held.time_ok && held.date_ok && held.active) begin
                status = (held.lat_ok && held.lon_ok) ? ST_RMC_POS : ST_RMC_NOP;
            end else if (held.kind == KIND_GGA && held.time_ok && held.lat_ok &&
                         held.lon_ok && held.fix_ok) begin
                status = ST_GGA;
            end
        end
        lat_o = held.lat_neg ? 31'd0 - lat_mag : lat_mag;
        lon_o = held.lon_neg ? 32'd0 - {1'b0, lon_mag} : {1'b0, lon_mag};
        alt_o = held.alt_neg ? 28'd0 - {1'b0, held.alt_mag} : {1'b0, held.alt_mag};

        m_data_next = '0;
        case (status)
            ST_RMC_NOP, ST_RMC_POS: begin
                m_data_next[26:0]  = held.time_ms;
                m_data_next[31:27] = held.day;
                m_data_next[35:32] = held.month;
                m_data_next[47:36] = held.year;
                if (status == ST_RMC_POS) begin
                    m_data_next[78:48]  = lat_o;
                    m_data_next[110:79] = lon_o;
                end
            end
            ST_GGA: begin
                m_data_next[26:0]    = held.time_ms;
                m_data_next[78:48]   = lat_o;
                m_data_next[110:79]  = lon_o;
                m_data_next[118:111] = held.fix;
                m_data_next[126:119] = held.present[0] ? held.sats : 8'd0;
                m_data_next[142:127] = held.present[1] ? held.hdop : 16'd0;
                m_data_next[170:143] = held.present[2] ? alt_o : 28'd0;
                m_data_next[173:171] = held.present;
            end
            default: ;
        endcase
        m_user_next = status;

        if (xfer && s_tlast) m_valid_next = 1'b1;
        else if (m_tready)   m_valid_next = 1'b0;
        else                 m_valid_next = m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            xor_reg     <= '0;
            recv_reg    <= '0;
            fn_reg      <= '0;
            fl_reg      <= '0;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            xor_reg     <= xor_next;
            recv_reg    <= recv_next;
            fn_reg      <= fn_next;
            fl_reg      <= fl_next;
            err_reg     <= err_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer && s_tlast) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

>>> sim/nmea_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nmea_result_checker
// Watches both streams of the sentence parser, predicts the verdict of each
// sentence from the accepted characters and compares every result transfer
// field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module nmea_result_checker
    import ngr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [175:0] m_tdata,
    input  logic [1:0]   m_tuser,
    output int           errors,
    output int           pending
);

    typedef enum int {FR_WAIT_DOLLAR, FR_BODY, FR_HEX1, FR_HEX2, FR_TAIL} frame_t;

    typedef struct {
        bit          ok;
        bit          neg;
        bit          nonzero;
        longint unsigned whole;
        longint unsigned frac;
        int          fcnt;
    } dec_t;

    typedef struct {
        bit          time_ok;
        int unsigned time_ms;
        bit          active;
        bit          date_ok;
        int unsigned day, month, year;
        bit          lat_ok, lat_neg;
        int unsigned lat_mag;
        bit          lon_ok, lon_neg;
        int unsigned lon_mag;
        bit          fix_ok;
        int unsigned fix, sats, hdop, present, alt_mag;
        bit          alt_neg;
    } fix_rec_t;

    typedef struct {
        status_t      st;
        logic [175:0] data;
    } verdict_t;

    localparam int NF = 12;
    localparam int FW [NF] = '{27, 5, 4, 12, 31, 32, 8, 8, 16, 28, 3, 2};
    localparam string FN [NF] = '{"time_of_day_ms", "day", "month", "year", "latitude",
        "longitude", "fix_qual", "satellites", "hdop_centi", "altitude_cm",
        "present_mask", "pad"};
    localparam longint unsigned WHOLE_LIMIT = 64'd1000000000000000;

    frame_t      frame;
    logic [7:0]  sum_calc, sum_rcvd;
    int          fld_idx, fld_len;
    kind_t       kind;
    logic [7:0]  dir_ch;
    bit          err;
    fix_rec_t    rec;
    logic [7:0]  fbuf [16];
    verdict_t    verdicts [$];

    assign pending = verdicts.size();

    function automatic void clear_sentence();
        frame    = FR_WAIT_DOLLAR;
        sum_calc = '0;
        sum_rcvd = '0;
        fld_idx  = 0;
        fld_len  = 0;
        kind     = KIND_NONE;
        dir_ch   = '0;
        err      = 0;
        rec      = '{default: 0};
        foreach (fbuf[i]) fbuf[i] = '0;
    endfunction

    function automatic dec_t scan_dec(int st, int len, bit allow_pt);
        dec_t       n;
        int         i;
        int         digits;
        bit         pt;
        logic [7:0] c;
        n = '{default: 0};
        i = 0;
        digits = 0;
        pt = 0;
        if (len == 0 || len > FIELD_CHARS_MAX) return n;
        if (fbuf[st] == CH_PLUS || fbuf[st] == CH_MINUS) begin
            n.neg = (fbuf[st] == CH_MINUS);
            i = 1;
        end
        for (; i < len; i++) begin
            c = fbuf[st + i];
            if (c >= CH_0 && c <= CH_9) begin
                digits++;
                if (c != CH_0) n.nonzero = 1;
                if (!pt) begin
                    if (n.whole < WHOLE_LIMIT) n.whole = n.whole * 10 + (c - CH_0);
                    if (n.whole > WHOLE_LIMIT) n.whole = WHOLE_LIMIT;
                end else if (n.fcnt < 8) begin
                    n.frac = n.frac * 10 + (c - CH_0);
                    n.fcnt++;
                end
            end else if (c == CH_DOT && allow_pt && !pt) begin
                pt = 1;
            end else begin
                return n;
            end
        end
        if (digits == 0) return n;
        while (n.fcnt < 8) begin
            n.frac = n.frac * 10;
            n.fcnt++;
        end
        n.ok = 1;
        return n;
    endfunction

    // -1 on failure
    function automatic longint two_digit(int st, longint max);
        dec_t n;
        n = scan_dec(st, 2, 0);
        if (!n.ok || (n.neg && n.whole != 0) || n.whole > max) return -1;
        return longint'(n.whole);
    endfunction

    function automatic void take_time(int len);
        longint hh, mm;
        dec_t   s;
        rec.time_ok = 0;
        if (len < 6 || len > FIELD_CHARS_MAX) return;
        hh = two_digit(0, 23);
        if (hh < 0) return;
        mm = two_digit(2, 59);
        if (mm < 0) return;
        s = scan_dec(4, len - 4, 1);
        if (!s.ok || (s.neg && s.nonzero) || s.whole >= 60) return;
        rec.time_ms = (hh * 3600 + mm * 60) * 1000 + s.whole * 1000 + s.frac / 100000;
        rec.time_ok = 1;
    endfunction

    function automatic void take_date(int len);
        longint d, m, y;
        rec.date_ok = 0;
        if (len != 6) return;
        d = two_digit(0, 31);
        if (d < 0) return;
        m = two_digit(2, 12);
        if (m < 0) return;
        y = two_digit(4, 99);
        if (y < 0 || d < 1 || m < 1) return;
        rec.day = d;
        rec.month = m;
        rec.year = (y >= 80) ? 1900 + y : 2000 + y;
        rec.date_ok = 1;
    endfunction

    function automatic bit take_coord(int len, bit is_lat, inout int unsigned mag);
        dec_t            n;
        longint unsigned deg, mins, maxdeg, mfix;
        n = scan_dec(0, len, 1);
        maxdeg = is_lat ? 90 : 180;
        if (!n.ok || (n.neg && n.nonzero)) return 0;
        deg = n.whole / 100;
        mins = n.whole % 100;
        if (deg > maxdeg || mins >= 60) return 0;
        if (deg == maxdeg && (mins != 0 || n.frac != 0)) return 0;
        mfix = mins * 100000 + n.frac / 1000;
        mag = deg * 10000000 + mfix * 10000000 / 6000000;
        return 1;
    endfunction

    function automatic bit take_dir(int len, logic [7:0] pos, logic [7:0] negc, inout bit neg);
        dir_ch = (len >= 1 && len <= FIELD_CHARS_MAX) ? fbuf[0] : 8'h00;
        neg = (len == 1 && dir_ch == negc);
        return len == 1 && (dir_ch == pos || dir_ch == negc);
    endfunction

    function automatic void close_field();
        int   len;
        dec_t n;
        len = fld_len;
        if (fld_idx == 0) begin
            kind = KIND_NONE;
            if (len == 6 && fbuf[0] == CH_DOLLAR) begin
                if (fbuf[3] == CH_R && fbuf[4] == CH_M && fbuf[5] == CH_C) kind = KIND_RMC;
                else if (fbuf[3] == CH_G && fbuf[4] == CH_G && fbuf[5] == CH_A) kind = KIND_GGA;
            end
            return;
        end
        if (fld_idx == 1 && kind != KIND_NONE) begin
            take_time(len);
            return;
        end
        if (kind == KIND_RMC) begin
            case (fld_idx)
                2: rec.active = (len == 1 && fbuf[0] == CH_A);
                3: rec.lat_ok = take_coord(len, 1, rec.lat_mag);
                4: rec.lat_ok = take_dir(len, CH_N, CH_S, rec.lat_neg) && rec.lat_ok;
                5: rec.lon_ok = take_coord(len, 0, rec.lon_mag);
                6: rec.lon_ok = take_dir(len, CH_E, CH_W, rec.lon_neg) && rec.lon_ok;
                9: take_date(len);
                default: ;
            endcase
        end else if (kind == KIND_GGA) begin
            case (fld_idx)
                2: rec.lat_ok = take_coord(len, 1, rec.lat_mag);
                3: rec.lat_ok = take_dir(len, CH_N, CH_S, rec.lat_neg) && rec.lat_ok;
                4: rec.lon_ok = take_coord(len, 0, rec.lon_mag);
                5: rec.lon_ok = take_dir(len, CH_E, CH_W, rec.lon_neg) && rec.lon_ok;
                6: begin
                    n = scan_dec(0, len, 0);
                    rec.fix_ok = n.ok && !n.neg && n.whole > 0;
                    rec.fix = (n.whole > 255) ? 255 : n.whole;
                end
                7: begin
                    n = scan_dec(0, len, 0);
                    if (n.ok) begin
                        rec.present |= 1;
                        rec.sats = n.neg ? 0 : (n.whole > 255 ? 255 : n.whole);
                    end
                end
                8: begin
                    n = scan_dec(0, len, 1);
                    if (n.ok) begin
                        rec.present |= 2;
                        n.whole = n.whole * 100 + n.frac / 1000000;
                        rec.hdop = n.neg ? 0 : (n.whole > 65535 ? 65535 : n.whole);
                    end
                end
                9: begin
                    n = scan_dec(0, len, 1);
                    if (n.ok) begin
                        rec.present |= 4;
                        n.whole = n.whole * 100 + n.frac / 1000000;
                        rec.alt_mag = n.whole > 100000000 ? 100000000 : n.whole;
                        rec.alt_neg = n.neg;
                    end
                end
                default: ;
            endcase
        end
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic logic [31:0] signed_mag(int unsigned mag, bit neg);
        return neg ? (32'd0 - mag) : mag;
    endfunction

    function automatic verdict_t make_verdict();
        verdict_t    v;
        logic [31:0] lat, lon, alt;
        v.st = ST_REJECT;
        v.data = '0;
        lat = signed_mag(rec.lat_mag, rec.lat_neg);
        lon = signed_mag(rec.lon_mag, rec.lon_neg);
        alt = signed_mag(rec.alt_mag, rec.alt_neg);
        if (!err && frame == FR_TAIL && sum_calc == sum_rcvd && fld_idx >= 9) begin
            if (kind == KIND_RMC && rec.time_ok && rec.date_ok && rec.active) begin
                v.st = (rec.lat_ok && rec.lon_ok) ? ST_RMC_POS : ST_RMC_NOP;
                v.data[26:0]  = rec.time_ms[26:0];
                v.data[31:27] = rec.day[4:0];
                v.data[35:32] = rec.month[3:0];
                v.data[47:36] = rec.year[11:0];
                if (v.st == ST_RMC_POS) begin
                    v.data[78:48]  = lat[30:0];
                    v.data[110:79] = lon;
                end
            end else if (kind == KIND_GGA && rec.time_ok && rec.lat_ok && rec.lon_ok &&
                         rec.fix_ok) begin
                v.st = ST_GGA;
                v.data[26:0]    = rec.time_ms[26:0];
                v.data[78:48]   = lat[30:0];
                v.data[110:79]  = lon;
                v.data[118:111] = rec.fix[7:0];
                v.data[126:119] = rec.sats[7:0];
                v.data[142:127] = rec.hdop[15:0];
                v.data[170:143] = alt[27:0];
                v.data[173:171] = rec.present[2:0];
            end
        end
        return v;
    endfunction

    function automatic void take_char(logic [7:0] b, logic last);
        int h;
        case (frame)
            FR_WAIT_DOLLAR: begin
                if (b == CH_DOLLAR) begin
                    frame = FR_BODY;
                    fbuf[0] = b;
                    fld_len = 1;
                end else begin
                    err = 1;
                    frame = FR_TAIL;
                end
            end
            FR_BODY: begin
                if (b == CH_STAR) begin
                    close_field();
                    frame = FR_HEX1;
                end else begin
                    sum_calc ^= b;
                    if (b == CH_COMMA) begin
                        close_field();
                        if (fld_idx < FIELDS_MAX) fld_idx++;
                        fld_len = 0;
                    end else begin
                        if (fld_len < FIELD_CHARS_MAX) fbuf[fld_len] = b;
                        if (fld_len <= FIELD_CHARS_MAX) fld_len++;
                    end
                end
            end
            FR_HEX1, FR_HEX2: begin
                h = hex_digit(b);
                if (h < 0) err = 1;
                else if (frame == FR_HEX1) sum_rcvd = 8'(h << 4);
                else sum_rcvd = sum_rcvd | 8'(h);
                frame = (frame == FR_HEX1) ? FR_HEX2 : FR_TAIL;
            end
            default: ;
        endcase
        if (last) begin
            verdicts = {verdicts, make_verdict()};
            clear_sentence();
        end
    endfunction

    always @(posedge aclk) begin
        verdict_t    v;
        logic [31:0] e, a;
        int          lo;
        if (!aresetn) begin
            clear_sentence();
            verdicts.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t: result with no sentence pending, status %0d data %h",
                             $realtime, m_tuser, m_tdata);
                    errors++;
                end else begin
                    v = verdicts.pop_front();
                    if (m_tuser !== v.st) begin
                        $display("%0t: status expected %0d actual %0d", $realtime, v.st, m_tuser);
                        errors++;
                    end
                    lo = 0;
                    for (int f = 0; f < NF; f++) begin
                        e = 32'((v.data >> lo) & ((176'd1 << FW[f]) - 1));
                        a = 32'((m_tdata >> lo) & ((176'd1 << FW[f]) - 1));
                        if (e !== a) begin
                            $display("%0t: %s expected %h actual %h", $realtime, FN[f], e, a);
                            errors++;
                        end
                        lo += FW[f];
                    end
                end
            end
            if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Sentence parser test: directed NMEA sentences for the corner cases, then
// random well-formed and damaged RMC/GGA sentences plus byte noise, under
// several sender idle and receiver stall mixes. Checking is done by
// nmea_result_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import ngr_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic [1:0]   m_tuser;
    int           errors, pending;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;
    int           sent;
    string        s;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    nmea_gga_rmc_sentence_parser_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    nmea_result_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    function automatic string nmea(string body, bit lower = 0);
        logic [7:0] x;
        x = '0;
        for (int i = 0; i < body.len(); i++) x ^= body[i];
        return lower ? $sformatf("$%s*%02x", body, x) : $sformatf("$%s*%02X", body, x);
    endfunction

    function automatic string digits(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = $sformatf("%s%0d", s, $urandom_range(9));
        return s;
    endfunction

    function automatic string junk();
        string cs, s;
        cs = "0123456789.+-ANSEWV$x ";
        s = "";
        repeat ($urandom_range(18)) s = {s, string'(cs[$urandom_range(cs.len() - 1)])};
        return s;
    endfunction

    function automatic string frac_part();
        return ($urandom_range(3) != 0) ? {".", digits($urandom_range(9))} : "";
    endfunction

    function automatic string rand_time();
        int r;
        r = $urandom_range(11);
        if (r == 0) return junk();
        if (r == 1) return {"-0+1-0", frac_part()};
        return {$sformatf("%02d%02d%02d", $urandom_range(r == 2 ? 29 : 23),
                          $urandom_range(59), $urandom_range(r == 3 ? 69 : 59)), frac_part()};
    endfunction

    function automatic string rand_coord(bit lat);
        int r, deg, mins;
        string s;
        r = $urandom_range(11);
        deg = $urandom_range(lat ? 90 : 180);
        mins = (r == 2) ? $urandom_range(60, 99) : $urandom_range(59);
        if (r == 0) return junk();
        if (r == 1) return lat ? "9000.00000" : "18000.000";
        s = lat ? $sformatf("%02d%02d", deg, mins) : $sformatf("%03d%02d", deg, mins);
        s = {s, frac_part()};
        if (r == 3) s = {"-", s};
        if (r == 4) s = lat ? "-0000.0" : "-00000";
        return s;
    endfunction

    function automatic string rand_dir(string pos, string negc);
        int r;
        r = $urandom_range(9);
        if (r == 0) return "";
        if (r == 1) return "X";
        if (r == 2) return {pos, negc};
        return (r & 1) ? pos : negc;
    endfunction

    function automatic string rand_small(int hi);
        int r;
        r = $urandom_range(9);
        if (r == 0) return junk();
        if (r == 1) return $sformatf("-%0d", $urandom_range(hi));
        if (r == 2) return digits($urandom_range(1, 17));
        return $sformatf("%0d", $urandom_range(hi));
    endfunction

    function automatic string rand_sentence();
        string tk, body, s;
        int    r;
        tk = ($urandom_range(3) == 0) ? {string'(8'($urandom_range(65, 90))),
                                         string'(8'($urandom_range(65, 90)))} : "GP";
        r = $urandom_range(19);
        if ($urandom_range(1)) begin
            body = {tk, (r == 0) ? "RMX," : "RMC,", rand_time(), ",",
                    ($urandom_range(7) == 0) ? "V" : "A", ",",
                    rand_coord(1), ",", rand_dir("N", "S"), ",",
                    rand_coord(0), ",", rand_dir("E", "W"), ",",
                    rand_small(500), frac_part(), ",", rand_small(359), ",",
                    ($urandom_range(9) == 0) ? junk() :
                        $sformatf("%02d%02d%02d", $urandom_range(31), $urandom_range(12),
                                  $urandom_range(99)), ",,"};
        end else begin
            body = {tk, (r == 0) ? "GGX," : "GGA,", rand_time(), ",",
                    rand_coord(1), ",", rand_dir("N", "S"), ",",
                    rand_coord(0), ",", rand_dir("E", "W"), ",",
                    rand_small(9), ",", rand_small(40), ",",
                    rand_small(99), frac_part(), ",", rand_small(9000), frac_part(),
                    ",M,,M,,"};
        end
        if (r == 1) body = {body, ",,,,,,,,,,,,,,,,,,,,,,,"};
        if (r == 2) body = tk;
        s = nmea(body, r == 3);
        if (r == 4) s[s.len() - 1] = (s[s.len() - 1] == "0") ? "1" : "0";
        if (r == 5) s = s.substr(0, s.len() - 1 - $urandom_range(1, 3));
        if (r == 6) s = {s, junk(), "*", digits(2)};
        if (r == 7) s[s.len() - 2] = "g";
        if (r == 8) s = {"#", s.substr(1, s.len() - 1)};
        return s;
    endfunction

    initial begin
        sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text(nmea("GPRMC,123519.50,A,4807.03812,N,01131.00000,E,022.4,084.4,230394,003.1,W"));
        send_text(nmea("GNRMC,235959.999,V,,,,,,,010180,,"));
        send_text(nmea("GPGGA,000000,9000.0000,S,18000.00000,W,9,99,99.99,-123.45,M,,M,,"));
        send_text(nmea("GPGGA,235959.9,0000.000,N,00000.0,E,300,-5,-1.5,9999999999,M,,", 1));
        send_text(nmea("GPGGA,120000,1234.5678,N,12345.6789,E,0,08,0.9,545.4,M,,M,,"));
        send_text({"X", nmea("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,,")});
        s = nmea("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,,");
        send_text(s.substr(0, s.len() - 2));
        send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,,,230394,,*G1");
        send_text({nmea("GPRMC,010203,A,0100.5,S,17959.99999,W,,,311299,,"), "Z*Q$"});
        send_text(nmea("GPRMC,12$519,A,4807.038,N,01131.000,E,,,230394,,"));
        send_text(nmea("GPRMC,123519.0000000000000,A,4807.038,N,01131.000,E,,,230394,,"));
        send_text(nmea("GPRMC,123519,A,4807.038,N,01131.000,E,,,230394,,,,,,,,,,,,,,,,,,,,,,,,,,"));
        send_text(nmea("GPRMC,123519,A,4807.038,N"));
        send_text(nmea("GPRMC,-0+1-0.0,A,-0000.0,N,-0100.0,E,,,+1+2-0,,"));
        send_text(nmea("GPRMC,+1-0-0.5,A,0000.0,N,00000,E,,,-1+2-0,,"));
        send_byte(CH_DOLLAR, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 53 : (ph == 3) ? 29 : 0;
            stall_pct = (ph == 2) ? 53 : (ph == 3) ? 29 : 0;
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(7) == 0) begin
                    r_noise();
                end else begin
                    send_text(rand_sentence());
                end
            end
            drain();
        end

        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    task automatic r_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)), i == n - 1);
    endtask

endmodule

>>> filelist.f
hdl/ngr_pkg.sv
hdl/ngr_coord_cvt.sv
hdl/ngr_field_dec.sv
hdl/nmea_gga_rmc_sentence_parser_top.sv
sim/nmea_result_checker.sv
sim/tb_top.sv
